// ===== rtl/core/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants of the ANSI text terminal
// Item and command layouts, character codes, state encodings and the SGR
// colour helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package att_pkg;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd1;

    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] LBRACKET     = 8'h5B;
    localparam logic [7:0] SEMICOLON    = 8'h3B;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] CHAR_K       = 8'h4B;
    localparam logic [7:0] CHAR_M       = 8'h6D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] DIGIT_0      = 8'h30;
    localparam logic [7:0] DIGIT_9      = 8'h39;
    localparam logic [7:0] FINAL_LO     = 8'h40;
    localparam logic [7:0] FINAL_HI     = 8'h7E;
    localparam logic [7:0] TAB_BYTE     = 8'h09;
    localparam logic [7:0] CR_BYTE      = 8'h0D;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;
    localparam logic [7:0] PARAM_MAX    = 8'd255;
    localparam logic [7:0] SGR_FG_LO    = 8'd30;
    localparam logic [7:0] SGR_FG_HI    = 8'd37;
    localparam logic [7:0] SGR_BG_LO    = 8'd40;
    localparam logic [7:0] SGR_BG_HI    = 8'd47;
    localparam logic [7:0] SGR_BOLD     = 8'd1;
    localparam logic [7:0] SGR_NORMAL   = 8'd22;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row_now;
        logic [6:0] cursor_column_now;
        logic [7:0] current_attr;
        logic       in_escape;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    // attr is the attribute after this item; it is also the one used for writes.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
        logic       esc;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGIT,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_PUT_ADDR,
        ST_PUT,
        ST_CLEAR,
        ST_DONE
    } back_state_t;

    function automatic logic [2:0] palette(input logic [2:0] idx);
        logic [2:0] colour;
        unique case (idx)
            3'd0: colour = 3'd0;
            3'd1: colour = 3'd4;
            3'd2: colour = 3'd2;
            3'd3: colour = 3'd6;
            3'd4: colour = 3'd1;
            3'd5: colour = 3'd5;
            3'd6: colour = 3'd3;
            3'd7: colour = 3'd7;
        endcase
        return colour;
    endfunction

    function automatic logic [7:0] apply_sgr(input logic [7:0] attr, input logic [7:0] val);
        logic [7:0] result;
        logic [7:0] offs;
        result = attr;
        offs   = 8'd0;
        priority if (val >= SGR_FG_LO && val <= SGR_FG_HI)
        begin
            offs   = val - SGR_FG_LO;
            result = {attr[7:4], 1'b0, palette(offs[2:0])};
        end
        else if (val >= SGR_BG_LO && val <= SGR_BG_HI)
        begin
            offs   = val - SGR_BG_LO;
            result = {1'b0, palette(offs[2:0]), attr[3:0]};
        end
        else if (val == SGR_BOLD)
        begin
            result = {attr[7:4], 1'b1, attr[2:0]};
        end
        else if (val == SGR_NORMAL)
        begin
            result = {attr[7:4], 1'b0, attr[2:0]};
        end
        else
        begin
            result = attr;
        end
        return result;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == BLANK_CHAR) || (c >= TAB_BYTE && c <= CR_BYTE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= DIGIT_0) && (c <= DIGIT_9);
    endfunction

endpackage

// ===== rtl/core/att_req_if.sv =====
// ----------------------------------------------------------------------------
// att_req_if: input item channel
// Valid/ready channel carrying one put or read item per transfer.
// ----------------------------------------------------------------------------
interface att_req_if import att_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/att_rsp_if.sv =====
// ----------------------------------------------------------------------------
// att_rsp_if: result item channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface att_rsp_if import att_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ansi_text_terminal.sv =====
// ----------------------------------------------------------------------------
// ansi_text_terminal: character-cell text terminal with ANSI escape decoding
// Front classifier, two-entry command queue and cell store sequencer.
// ----------------------------------------------------------------------------
// Path: a printable byte passes the sequencer's decode and address multiply;
// a read passes its decode, address multiply and registered memory read.
// A deferred scroll copies the rows up and blanks the bottom row before the put
// or newline that caused it; a line clear blanks from the cursor to row end.
// The front takes new items while the sequencer works, until the queue is full.
// Reset: a clearing pass fills every cell before the first item is accepted.
module ansi_text_terminal import att_pkg::*;
#(
    parameter int MAX_COLUMNS  = 80,
    parameter int MAX_ROWS     = 25,
    parameter int ESCAPE_DEPTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    att_req_if.sink                req,
    att_rsp_if.source              rsp
);

    logic init_done;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    att_front #(
        .ESCAPE_DEPTH(ESCAPE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .init_done(init_done),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    att_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_data (pop_cmd),
        .empty    (q_empty)
    );

    att_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (pop_cmd),
        .q_pop    (pop),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .rsp      (rsp),
        .init_done(init_done)
    );

endmodule

// ===== rtl/core/att_queue.sv =====
// ----------------------------------------------------------------------------
// att_queue: two-entry command queue
// Decouples the byte classifier from the cell store sequencer.
// ----------------------------------------------------------------------------
module att_queue import att_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/att_front.sv =====
// ----------------------------------------------------------------------------
// att_front: byte classifier and escape decoder
// Accepts items, tracks escape sequences and the current attribute, parses
// SGR parameters as they arrive and queues one command per item.
// ----------------------------------------------------------------------------
module att_front import att_pkg::*;
#(
    parameter int ESCAPE_DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    att_req_if.sink req,
    input  logic init_done,
    input  logic q_full,
    output logic push,
    output cmd_t push_cmd
);

    localparam int LEN_W = $clog2(ESCAPE_DEPTH + 1);

    logic [LEN_W-1:0] esc_len_reg;
    logic [LEN_W-1:0] esc_len_next;
    logic [7:0]       text_attr_reg;
    logic [7:0]       text_attr_next;
    logic [7:0]       pend_attr_reg;
    logic [7:0]       pend_attr_next;
    parse_phase_t     phase_reg;
    parse_phase_t     phase_next;
    logic             neg_reg;
    logic             neg_next;
    logic [7:0]       val_reg;
    logic [7:0]       val_next;

    logic [7:0]  c;
    logic        stored;
    logic [11:0] acc;
    logic [7:0]  acc_sat;
    logic [7:0]  fin_attr;

    assign req.ready = init_done && !q_full;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        c        = req.data.char_code;
        stored   = (esc_len_reg < LEN_W'(ESCAPE_DEPTH));
        acc      = 12'(val_reg) * 12'd10 + {8'd0, c[3:0]};
        acc_sat  = (acc > 12'(PARAM_MAX)) ? PARAM_MAX : acc[7:0];
        // A parameter whose terminator made it into the buffer is applied.
        fin_attr = neg_reg ? pend_attr_reg : apply_sgr(pend_attr_reg, val_reg);

        esc_len_next   = esc_len_reg;
        text_attr_next = text_attr_reg;
        pend_attr_next = pend_attr_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;

        push_cmd      = '0;
        push_cmd.kind = CMD_NOP;
        push_cmd.ch   = c;
        push_cmd.row  = req.data.read_row;
        push_cmd.col  = req.data.read_column;

        priority if (req.data.operation)
        begin
            push_cmd.kind = CMD_READ;
        end
        else if (c == ESC_BYTE)
        begin
            esc_len_next   = LEN_W'(1);
            pend_attr_next = text_attr_reg;
            phase_next     = PH_BLANK;
            neg_next       = 1'b0;
            val_next       = 8'd0;
        end
        else if (esc_len_reg != '0)
        begin
            priority if (esc_len_reg == LEN_W'(1))
            begin
                esc_len_next = (c == LBRACKET) ? LEN_W'(2) : '0;
            end
            else if (c >= FINAL_LO && c <= FINAL_HI)
            begin
                esc_len_next = '0;
                if (c == CHAR_K)
                begin
                    push_cmd.kind = CMD_CLEAR;
                end
                else if (c == CHAR_M)
                begin
                    text_attr_next = stored ? fin_attr : pend_attr_reg;
                end
            end
            else if (stored)
            begin
                esc_len_next = esc_len_reg + LEN_W'(1);
                if (c == SEMICOLON)
                begin
                    pend_attr_next = fin_attr;
                    phase_next     = PH_BLANK;
                    neg_next       = 1'b0;
                    val_next       = 8'd0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_BLANK:
                        begin
                            priority if (is_blank(c))
                            begin
                                phase_next = PH_BLANK;
                            end
                            else if (c == CHAR_PLUS || c == CHAR_MINUS)
                            begin
                                neg_next   = (c == CHAR_MINUS);
                                phase_next = PH_DIGIT;
                            end
                            else if (is_digit(c))
                            begin
                                val_next   = acc_sat;
                                phase_next = PH_DIGIT;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DIGIT:
                        begin
                            if (is_digit(c))
                            begin
                                val_next = acc_sat;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end
        else if (c == NEWLINE_BYTE)
        begin
            push_cmd.kind = CMD_NEWLINE;
        end
        else
        begin
            push_cmd.kind = CMD_PUT;
        end

        push_cmd.attr = text_attr_next;
        push_cmd.esc  = (esc_len_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_len_reg   <= '0;
            text_attr_reg <= RESET_ATTR;
            pend_attr_reg <= RESET_ATTR;
            phase_reg     <= PH_BLANK;
            neg_reg       <= 1'b0;
            val_reg       <= 8'd0;
        end
        else if (push)
        begin
            esc_len_reg   <= esc_len_next;
            text_attr_reg <= text_attr_next;
            pend_attr_reg <= pend_attr_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            val_reg       <= val_next;
        end
    end

endmodule

// ===== rtl/core/att_back.sv =====
// ----------------------------------------------------------------------------
// att_back: cell store sequencer
// Holds the cell memory, the cursor and the screen size, carries out queued
// commands one at a time and registers one result per command.
// ----------------------------------------------------------------------------
module att_back import att_pkg::*;
#(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  cmd_t                   q_data,
    output logic                   q_pop,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    att_rsp_if.source              rsp,
    output logic                   init_done
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W     = $clog2(CELL_COUNT + 1);
    localparam int AIX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CW         = (COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W;
    localparam int RW         = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [COL_W-1:0]  cols_reg;
    logic [COL_W-1:0]  cols_next;
    logic [ROW_W-1:0]  rows_reg;
    logic [ROW_W-1:0]  rows_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [ADDR_W-1:0] end_reg;
    logic [ADDR_W-1:0] end_next;
    logic [15:0]       cell_reg;
    logic [15:0]       cell_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic [15:0]       cells_mem [CELL_COUNT];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic [AIX_W-1:0]  mem_waddr;
    logic [15:0]       mem_wdata;
    logic [AIX_W-1:0]  mem_raddr;

    logic [ROW_W-1:0]  mul_a;
    logic [ADDR_W-1:0] prod;
    logic [ADDR_W-1:0] cols_ext;
    logic              last;
    logic              slot_free;
    logic              scroll_pending;
    logic              read_in_range;
    logic              cfg_hit;
    logic [CW-1:0]     cfg_cols;
    logic [RW-1:0]     cfg_rows;
    logic [COL_W-1:0]  col_inc;

    assign init_done = (state_reg != ST_INIT);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign cols_ext       = ADDR_W'(cols_reg);
    assign prod           = ADDR_W'(mul_a) * cols_ext;
    assign last           = (ptr_reg == end_reg - ADDR_W'(1));
    assign slot_free      = !out_valid_reg || rsp.ready;
    assign scroll_pending = (cur_row_reg >= rows_reg);
    assign read_in_range  = (RW'(cmd_reg.row) < RW'(rows_reg)) &&
                            (CW'(cmd_reg.col) < CW'(cols_reg));
    assign col_inc        = cur_col_reg + COL_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (cmd_reg.kind)
                    CMD_READ:
                    begin
                        state_next = read_in_range ? ST_RD_ISSUE : ST_DONE;
                    end
                    CMD_PUT, CMD_NEWLINE:
                    begin
                        priority if (!scroll_pending)
                        begin
                            state_next = ST_PUT_ADDR;
                        end
                        else if (rows_reg == ROW_W'(1))
                        begin
                            state_next = ST_BLANK;
                        end
                        else
                        begin
                            state_next = ST_SCR_RD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = scroll_pending ? ST_DONE : ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_ISSUE: state_next = ST_RD_WAIT;
            ST_RD_WAIT:  state_next = ST_DONE;
            ST_SCR_RD:   state_next = ST_SCR_WR;
            ST_SCR_WR:   state_next = last ? ST_BLANK : ST_SCR_RD;
            ST_BLANK:    state_next = last ? ST_PUT_ADDR : ST_BLANK;
            ST_PUT_ADDR: state_next = ST_PUT;
            ST_PUT:      state_next = ST_DONE;
            ST_CLEAR:    state_next = last ? ST_DONE : ST_CLEAR;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AIX_W-1:0];
        mem_wdata      = {cmd_reg.attr, BLANK_CHAR};
        mem_raddr      = ptr_reg[AIX_W-1:0];
        mul_a          = cur_row_reg;
        cfg_hit        = 1'b0;
        cfg_cols       = CW'(cfg_data);
        cfg_rows       = RW'(cfg_data);

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                ptr_next  = ptr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                q_pop    = !q_empty;
                cmd_next = q_data;
            end
            ST_DECODE:
            begin
                cell_next = 16'd0;
                unique case (cmd_reg.kind)
                    CMD_READ:
                    begin
                        mul_a    = ROW_W'(cmd_reg.row);
                        ptr_next = prod + ADDR_W'(cmd_reg.col);
                    end
                    CMD_PUT, CMD_NEWLINE:
                    begin
                        // Scroll: copy rows up, then blank the bottom row.
                        mul_a    = rows_reg - ROW_W'(1);
                        ptr_next = '0;
                        end_next = (rows_reg == ROW_W'(1)) ? cols_ext : prod;
                    end
                    CMD_CLEAR:
                    begin
                        ptr_next = prod + ADDR_W'(cur_col_reg);
                        end_next = prod + cols_ext;
                    end
                    default:
                    begin
                        ptr_next = ptr_reg;
                    end
                endcase
            end
            ST_RD_ISSUE:
            begin
                mem_raddr = ptr_reg[AIX_W-1:0];
            end
            ST_RD_WAIT:
            begin
                cell_next = rd_data_reg;
            end
            ST_SCR_RD:
            begin
                mem_raddr = AIX_W'(ptr_reg + cols_ext);
            end
            ST_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_reg + ADDR_W'(1);
                if (last)
                begin
                    end_next = end_reg + cols_ext;
                end
            end
            ST_BLANK:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
                if (last)
                begin
                    cur_col_next = '0;
                    cur_row_next = rows_reg - ROW_W'(1);
                end
            end
            ST_PUT_ADDR:
            begin
                mul_a    = cur_row_reg;
                ptr_next = prod + ADDR_W'(cur_col_reg);
            end
            ST_PUT:
            begin
                if (cmd_reg.kind == CMD_NEWLINE)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + ROW_W'(1);
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {cmd_reg.attr, cmd_reg.ch};
                    if (col_inc >= cols_reg)
                    begin
                        cur_col_next = '0;
                        cur_row_next = cur_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        cur_col_next = col_inc;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
                if (last)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + ROW_W'(1);
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.cell_char         = cell_reg[7:0];
                    out_data_next.cell_attr         = cell_reg[15:8];
                    out_data_next.cursor_row_now    = 5'(cur_row_reg);
                    out_data_next.cursor_column_now = 7'(cur_col_reg);
                    out_data_next.current_attr      = cmd_reg.attr;
                    out_data_next.in_escape         = cmd_reg.esc;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        // User writes screen size only in idle, unchecked; cursor clamped after.
        if (cfg_write && cfg_index == REG_COLUMNS)
        begin
            cfg_hit = 1'b1;
            priority if (cfg_cols == '0)
            begin
                cols_next = COL_W'(1);
            end
            else if (cfg_cols > CW'(MAX_COLUMNS))
            begin
                cols_next = COL_W'(MAX_COLUMNS);
            end
            else
            begin
                cols_next = COL_W'(cfg_cols);
            end
        end
        else if (cfg_write && cfg_index == REG_ROWS)
        begin
            cfg_hit = 1'b1;
            priority if (cfg_rows == '0)
            begin
                rows_next = ROW_W'(1);
            end
            else if (cfg_rows > RW'(MAX_ROWS))
            begin
                rows_next = ROW_W'(MAX_ROWS);
            end
            else
            begin
                rows_next = ROW_W'(cfg_rows);
            end
        end

        if (cfg_hit)
        begin
            if (cur_col_reg >= cols_next)
            begin
                cur_col_next = cols_next - COL_W'(1);
            end
            if (cur_row_reg > rows_next)
            begin
                cur_row_next = rows_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cells_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        end_reg      <= end_next;
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cols_reg      <= COL_W'(MAX_COLUMNS);
            rows_reg      <= ROW_W'(MAX_ROWS);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
